// File: sv/kclc_pkg.sv
`timescale 1ns / 1ps

package kclc_pkg;

    // Keypad positions with a special meaning
    localparam logic [3:0] KEY_STAR = 4'd12;
    localparam logic [3:0] KEY_HASH = 4'd14;

    // Request types
    localparam logic [1:0] REQ_KEY      = 2'd0;
    localparam logic [1:0] REQ_CARD     = 2'd1;
    localparam logic [1:0] REQ_CARD_ERR = 2'd2;

    // Status codes
    localparam logic [3:0] ST_IGNORED   = 4'd0;
    localparam logic [3:0] ST_ADDED     = 4'd1;
    localparam logic [3:0] ST_CLEARED   = 4'd2;
    localparam logic [3:0] ST_CODE_OK   = 4'd3;
    localparam logic [3:0] ST_CODE_BAD  = 4'd4;
    localparam logic [3:0] ST_CARD_OK   = 4'd5;
    localparam logic [3:0] ST_CARD_BAD  = 4'd6;
    localparam logic [3:0] ST_CARD_ERR  = 4'd7;
    localparam logic [3:0] ST_CLOSED    = 4'd8;
    localparam logic [3:0] ST_CANCELLED = 4'd9;

    // Configuration register indexes
    localparam logic [1:0] CFG_CODE_KEYS    = 2'd0;
    localparam logic [1:0] CFG_CODE_LENGTH  = 2'd1;
    localparam logic [1:0] CFG_CARD_PATTERN = 2'd2;

    // Configuration reset values
    localparam logic [63:0] RST_CODE_KEYS    = 64'h4210;
    localparam logic [4:0]  RST_CODE_LENGTH  = 5'd4;
    localparam logic [23:0] RST_CARD_PATTERN = 24'h527569;

    // Controller modes
    typedef enum logic [2:0] {
        MODE_ENTRY = 3'b001,
        MODE_CARD  = 3'b010,
        MODE_OPEN  = 3'b100
    } t_mode;

    typedef struct packed {
        logic [1:0] req_type;
        logic [3:0] key_code;
        logic [7:0] card_byte;
        logic       card_last;
    } t_req;

    typedef struct packed {
        logic [3:0] status;
        logic       lock_open;
        logic [4:0] entered_count;
    } t_rsp;

    // Streaming 3-byte pattern search; progress p means the last p bytes
    // equal the first p pattern bytes. A return of 3 is a full hit.
    function automatic logic [1:0] next_progress(
        input logic [1:0]  p,
        input logic [7:0]  c,
        input logic [23:0] pat
    );
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [1:0] res;
        b0 = pat[23:16];
        b1 = pat[15:8];
        b2 = pat[7:0];
        res = 2'd0;
        case (p)
            2'd1: begin
                if (c == b1)      res = 2'd2;
                else if (c == b0) res = 2'd1;
            end
            2'd2: begin
                if (c == b2)                   res = 2'd3;
                else if (b1 == b0 && c == b1)  res = 2'd2;
                else if (c == b0)              res = 2'd1;
            end
            default: begin
                if (c == b0) res = 2'd1;
            end
        endcase
        return res;
    endfunction

endpackage

// File: sv/kclc_stream_if.sv
`timescale 1ns / 1ps

// Valid/ready channel carrying one beat of type T
interface kclc_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: sv/kclc_in_reg.sv
`timescale 1ns / 1ps

// Input register: holds one request beat until the controller takes it
module kclc_in_reg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    kclc_stream_if.sink   i_req,
    input  logic          i_take,
    output logic          o_valid,
    output kclc_pkg::t_req o_req
);
    logic           r_valid;
    kclc_pkg::t_req r_req;

    assign i_req.ready = !r_valid || i_take;
    assign o_valid     = r_valid;
    assign o_req       = r_req;

    // Valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_valid <= i_req.valid;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_req <= i_req.data;
        end
    end
endmodule

// File: sv/kclc_ctrl.sv
`timescale 1ns / 1ps

// Lock controller state, config registers and per-beat update
module kclc_ctrl #(
    parameter int MAX_DIGITS = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic [1:0]     i_cfg_idx,
    input  logic [63:0]    i_cfg_data,
    input  logic           i_go,
    input  kclc_pkg::t_req i_req,
    output kclc_pkg::t_rsp o_rsp
);
    localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

    // Config registers
    logic [63:0] r_code_keys;
    logic [4:0]  r_code_len;
    logic [23:0] r_pattern;

    // Controller state
    kclc_pkg::t_mode r_mode, n_mode;
    logic [4:0]      r_cnt, n_cnt;
    logic            r_ovf, n_ovf;
    logic [1:0]      r_prog, n_prog;
    logic            r_found, n_found;
    logic            r_open, n_open;
    logic [3:0]      r_buf [MAX_DIGITS];

    logic            buf_we;
    logic [3:0]      status;
    logic            do_key;
    logic            code_ok;
    logic            can_append;
    logic [1:0]      srch;
    logic            hit;
    logic [MAX_DIGITS-1:0] key_ok;

    // Per-position compare of the entry against the code
    always_comb begin
        for (int i = 0; i < MAX_DIGITS; i++) begin
            key_ok[i] = (5'(i) >= r_cnt) || (r_buf[i] == r_code_keys[4*i +: 4]);
        end
    end

    assign code_ok    = !r_ovf && (r_cnt == r_code_len) && (&key_ok);
    assign can_append = r_cnt < 5'(MAX_DIGITS);
    assign srch       = kclc_pkg::next_progress(r_prog, i_req.card_byte, r_pattern);
    assign hit        = (srch == 2'd3);

    // Next state and status
    always_comb begin
        n_mode  = r_mode;
        n_cnt   = r_cnt;
        n_ovf   = r_ovf;
        n_prog  = r_prog;
        n_found = r_found;
        n_open  = r_open;
        buf_we  = 1'b0;
        do_key  = 1'b0;
        status  = kclc_pkg::ST_IGNORED;

        case (r_mode)
            kclc_pkg::MODE_OPEN: begin
                if (i_req.req_type == kclc_pkg::REQ_KEY) begin
                    if (i_req.key_code == kclc_pkg::KEY_HASH) begin
                        n_open = 1'b0;
                        status = kclc_pkg::ST_CLOSED;
                    end else begin
                        status = kclc_pkg::ST_CANCELLED;
                    end
                    n_mode  = kclc_pkg::MODE_ENTRY;
                    n_cnt   = 5'd0;
                    n_ovf   = 1'b0;
                    n_prog  = 2'd0;
                    n_found = 1'b0;
                end
            end
            kclc_pkg::MODE_CARD: begin
                if (i_req.req_type == kclc_pkg::REQ_KEY) begin
                    do_key = 1'b1;
                end else if (i_req.req_type == kclc_pkg::REQ_CARD) begin
                    n_prog  = hit ? 2'd0 : srch;
                    n_found = r_found || hit;
                    if (i_req.card_last) begin
                        if (n_found) begin
                            n_mode  = kclc_pkg::MODE_OPEN;
                            n_open  = 1'b1;
                            n_prog  = 2'd0;
                            n_found = 1'b0;
                            status  = kclc_pkg::ST_CARD_OK;
                        end else begin
                            n_mode  = kclc_pkg::MODE_ENTRY;
                            n_cnt   = 5'd0;
                            n_ovf   = 1'b0;
                            n_prog  = 2'd0;
                            n_found = 1'b0;
                            status  = kclc_pkg::ST_CARD_BAD;
                        end
                    end
                end else if (i_req.req_type == kclc_pkg::REQ_CARD_ERR) begin
                    n_mode  = kclc_pkg::MODE_ENTRY;
                    n_cnt   = 5'd0;
                    n_ovf   = 1'b0;
                    n_prog  = 2'd0;
                    n_found = 1'b0;
                    status  = kclc_pkg::ST_CARD_ERR;
                end
            end
            default: begin
                n_mode = kclc_pkg::MODE_ENTRY;
                if (i_req.req_type == kclc_pkg::REQ_KEY) begin
                    do_key = 1'b1;
                end
            end
        endcase

        // Key handling, shared by entry and card wait
        if (do_key) begin
            if (i_req.key_code == kclc_pkg::KEY_STAR) begin
                n_cnt  = 5'd0;
                n_ovf  = 1'b0;
                status = kclc_pkg::ST_CLEARED;
            end else if (i_req.key_code == kclc_pkg::KEY_HASH) begin
                if (code_ok) begin
                    n_mode  = kclc_pkg::MODE_CARD;
                    n_prog  = 2'd0;
                    n_found = 1'b0;
                    status  = kclc_pkg::ST_CODE_OK;
                end else begin
                    n_mode  = kclc_pkg::MODE_ENTRY;
                    n_cnt   = 5'd0;
                    n_ovf   = 1'b0;
                    n_prog  = 2'd0;
                    n_found = 1'b0;
                    status  = kclc_pkg::ST_CODE_BAD;
                end
            end else begin
                if (can_append) begin
                    buf_we = 1'b1;
                    n_cnt  = r_cnt + 5'd1;
                end else begin
                    n_ovf = 1'b1;
                end
                status = kclc_pkg::ST_ADDED;
            end
        end
    end

    assign o_rsp.status        = status;
    assign o_rsp.lock_open     = n_open;
    assign o_rsp.entered_count = n_cnt;

    // Config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code_keys <= kclc_pkg::RST_CODE_KEYS;
            r_code_len  <= kclc_pkg::RST_CODE_LENGTH;
            r_pattern   <= kclc_pkg::RST_CARD_PATTERN;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                kclc_pkg::CFG_CODE_KEYS:    r_code_keys <= i_cfg_data;
                kclc_pkg::CFG_CODE_LENGTH:  r_code_len  <= i_cfg_data[4:0];
                kclc_pkg::CFG_CARD_PATTERN: r_pattern   <= i_cfg_data[23:0];
                default: ;
            endcase
        end
    end

    // Controller state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= kclc_pkg::MODE_ENTRY;
            r_cnt   <= 5'd0;
            r_ovf   <= 1'b0;
            r_prog  <= 2'd0;
            r_found <= 1'b0;
            r_open  <= 1'b0;
        end else if (i_go) begin
            r_mode  <= n_mode;
            r_cnt   <= n_cnt;
            r_ovf   <= n_ovf;
            r_prog  <= n_prog;
            r_found <= n_found;
            r_open  <= n_open;
        end
    end

    // Entry buffer, no reset: only written slots are compared
    always_ff @(posedge i_clk) begin
        if (i_go && buf_we) begin
            r_buf[r_cnt[IDX_W-1:0]] <= i_req.key_code;
        end
    end
endmodule

// File: sv/kclc_out_reg.sv
`timescale 1ns / 1ps

// Result register: holds one result beat until the sink takes it
module kclc_out_reg (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_load,
    input  kclc_pkg::t_rsp i_rsp,
    output logic           o_can_load,
    kclc_stream_if.source  o_rsp
);
    logic           r_valid;
    kclc_pkg::t_rsp r_rsp;

    assign o_can_load  = !r_valid || o_rsp.ready;
    assign o_rsp.valid = r_valid;
    assign o_rsp.data  = r_rsp;

    // Valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_load;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (i_load && o_can_load) begin
            r_rsp <= i_rsp;
        end
    end
endmodule

// File: sv/keypad_card_lock_controller_top.sv
`timescale 1ns / 1ps
// A request beat passes through the input register, then one pass of compare/update logic
//   into the result register.
// Throughput: one beat per cycle; ready drops only when both registers are full and
//   the result sink stalls.
// Reset (synchronous, active low): entry mode, empty entry, lock closed, config at defaults.
module keypad_card_lock_controller_top #(
    parameter int MAX_DIGITS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_idx,
    input  logic [63:0]   i_cfg_data,
    kclc_stream_if.sink   i_req,
    kclc_stream_if.source o_rsp
);
    logic           req_valid;
    kclc_pkg::t_req req;
    kclc_pkg::t_rsp rsp;
    logic           can_load;
    logic           go;

    // Advance the held request when the result register has room
    assign go = req_valid && can_load;

    kclc_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_take  (can_load),
        .o_valid (req_valid),
        .o_req   (req)
    );

    kclc_ctrl #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_go       (go),
        .i_req      (req),
        .o_rsp      (rsp)
    );

    kclc_out_reg u_out_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (req_valid),
        .i_rsp      (rsp),
        .o_can_load (can_load),
        .o_rsp      (o_rsp)
    );
endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import kclc_pkg::*;

    localparam int MAX_KEYS    = 16;
    localparam int PHASE_ITEMS = 105;
    localparam int DRAIN_TICKS = 8;

    // Request type that the block must ignore
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    typedef enum logic [1:0] {
        OP_BEAT,
        OP_CFG,
        OP_DRAIN
    } t_op_kind;

    typedef struct {
        t_op_kind    kind;
        t_req        beat;
        logic [1:0]  idx;
        logic [63:0] value;
    } t_op;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [63:0] i_cfg_data;

    kclc_stream_if #(.T(t_req)) req_if ();
    kclc_stream_if #(.T(t_rsp)) rsp_if ();

    keypad_card_lock_controller_top #(
        .MAX_DIGITS(MAX_KEYS)
    ) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_req     (req_if.sink),
        .o_rsp     (rsp_if.source)
    );

    // Pending stimulus and expected results
    t_op  op_q[$];
    t_rsp rsp_expect_q[$];
    int   beats_sent = 0;
    int   beats_seen = 0;
    int   fail_cnt   = 0;
    int   stim_items = 0;

    // Lock model: configuration copy
    logic [63:0] code_keys_m;
    logic [4:0]  code_len_m;
    logic [23:0] pattern_m;

    // Lock model: controller state
    t_mode       mode_m;
    logic [3:0]  entry_m [MAX_KEYS];
    logic [4:0]  count_m;
    logic        ovf_m;
    logic [1:0]  prog_m;
    logic        found_m;
    logic        open_m;

    // Code and pattern the stimulus is currently aimed at
    logic [63:0] plan_code;
    logic [4:0]  plan_len;
    logic [23:0] plan_pat;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // ---------------------------------------------------------------
    // Lock model
    // ---------------------------------------------------------------

    function automatic void clear_cycle();
        mode_m  = MODE_ENTRY;
        count_m = '0;
        ovf_m   = 1'b0;
        prog_m  = '0;
        found_m = 1'b0;
    endfunction

    function automatic void lock_model_reset();
        code_keys_m = 64'h4210;
        code_len_m  = 5'd4;
        pattern_m   = 24'h527569;
        foreach (entry_m[i]) entry_m[i] = '0;
        open_m = 1'b0;
        clear_cycle();
    endfunction

    function automatic void cfg_apply(input logic [1:0] idx, input logic [63:0] value);
        case (idx)
            CFG_CODE_KEYS:    code_keys_m = value;
            CFG_CODE_LENGTH:  code_len_m  = value[4:0];
            CFG_CARD_PATTERN: pattern_m   = value[23:0];
            default: ;
        endcase
    endfunction

    function automatic logic [7:0] pat_byte(input int i);
        return pattern_m[23 - 8 * i -: 8];
    endfunction

    // Longest tail of the bytes seen so far that is a head of the pattern
    function automatic logic [1:0] search_advance(input logic [1:0] p, input logic [7:0] c);
        logic [7:0] seen [3];
        int         len;
        bit         ok;
        for (int j = 0; j < p; j++) seen[j] = pat_byte(j);
        seen[p] = c;
        len = p + 1;
        for (int k = len; k > 0; k--) begin
            ok = 1'b1;
            for (int j = 0; j < k; j++) begin
                if (seen[len - k + j] != pat_byte(j)) ok = 1'b0;
            end
            if (ok) return 2'(k);
        end
        return 2'd0;
    endfunction

    function automatic bit code_ok();
        if (ovf_m || count_m != code_len_m || count_m > 5'd16) return 1'b0;
        for (int i = 0; i < count_m; i++) begin
            if (entry_m[i] != code_keys_m[4 * i +: 4]) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic logic [3:0] key_update(input logic [3:0] key);
        if (key == KEY_STAR) begin
            count_m = '0;
            ovf_m   = 1'b0;
            return ST_CLEARED;
        end
        if (key == KEY_HASH) begin
            if (code_ok()) begin
                mode_m  = MODE_CARD;
                prog_m  = '0;
                found_m = 1'b0;
                return ST_CODE_OK;
            end
            clear_cycle();
            return ST_CODE_BAD;
        end
        // full entry: key dropped, overflow forces the next compare to fail
        if (count_m < MAX_KEYS) begin
            entry_m[count_m[3:0]] = key;
            count_m++;
        end else begin
            ovf_m = 1'b1;
        end
        return ST_ADDED;
    endfunction

    function automatic t_rsp lock_predict(input t_req r);
        t_rsp       o;
        logic [3:0] st;
        logic [1:0] p;
        st = ST_IGNORED;
        case (mode_m)
            MODE_OPEN: begin
                if (r.req_type == REQ_KEY) begin
                    // hash closes; any other key cancels and leaves it open
                    if (r.key_code == KEY_HASH) begin
                        open_m = 1'b0;
                        st     = ST_CLOSED;
                    end else begin
                        st = ST_CANCELLED;
                    end
                    clear_cycle();
                end
            end
            MODE_CARD: begin
                if (r.req_type == REQ_KEY) begin
                    st = key_update(r.key_code);
                end else if (r.req_type == REQ_CARD) begin
                    p = search_advance(prog_m, r.card_byte);
                    if (p == 2'd3) begin
                        found_m = 1'b1;
                        p       = 2'd0;
                    end
                    prog_m = p;
                    if (r.card_last) begin
                        if (found_m) begin
                            mode_m  = MODE_OPEN;
                            open_m  = 1'b1;
                            prog_m  = '0;
                            found_m = 1'b0;
                            st      = ST_CARD_OK;
                        end else begin
                            clear_cycle();
                            st = ST_CARD_BAD;
                        end
                    end
                end else if (r.req_type == REQ_CARD_ERR) begin
                    clear_cycle();
                    st = ST_CARD_ERR;
                end
            end
            default: begin
                mode_m = MODE_ENTRY;
                if (r.req_type == REQ_KEY) st = key_update(r.key_code);
            end
        endcase
        o.status        = st;
        o.lock_open     = open_m;
        o.entered_count = count_m;
        return o;
    endfunction

    // ---------------------------------------------------------------
    // Stimulus builders
    // ---------------------------------------------------------------

    function automatic void add_beat(input logic [1:0] rt, input logic [3:0] key,
                                     input logic [7:0] byt, input logic is_last);
        t_op op;
        op.kind               = OP_BEAT;
        op.beat.req_type      = rt;
        op.beat.key_code      = key;
        op.beat.card_byte     = byt;
        op.beat.card_last     = is_last;
        op.idx                = CFG_CODE_KEYS;
        op.value              = '0;
        op_q.push_back(op);
        stim_items++;
    endfunction

    function automatic void add_key(input logic [3:0] key);
        add_beat(REQ_KEY, key, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    endfunction

    function automatic void add_card(input logic [7:0] byt, input logic is_last);
        add_beat(REQ_CARD, 4'($urandom_range(0, 15)), byt, is_last);
    endfunction

    function automatic void add_noise();
        add_beat(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
                 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    endfunction

    function automatic void add_cfg(input logic [1:0] idx, input logic [63:0] value);
        t_op op;
        op.kind  = OP_CFG;
        op.beat  = '0;
        op.idx   = idx;
        op.value = value;
        op_q.push_back(op);
    endfunction

    // Sender holds off until every outstanding result is back
    function automatic void add_drain();
        t_op op;
        op.kind  = OP_DRAIN;
        op.beat  = '0;
        op.idx   = CFG_CODE_KEYS;
        op.value = '0;
        op_q.push_back(op);
    endfunction

    function automatic void set_phase(input logic [63:0] code, input logic [4:0] len,
                                      input logic [23:0] pat);
        plan_code = code;
        plan_len  = len;
        plan_pat  = pat;
        add_cfg(CFG_CODE_KEYS, code);
        add_cfg(CFG_CODE_LENGTH, {59'd0, len});
        add_cfg(CFG_CARD_PATTERN, {40'd0, pat});
    endfunction

    function automatic logic [3:0] rand_digit();
        logic [3:0] k;
        k = 4'($urandom_range(0, 15));
        while (k == KEY_STAR || k == KEY_HASH) k = 4'($urandom_range(0, 15));
        return k;
    endfunction

    function automatic logic [63:0] rand_code();
        logic [63:0] c;
        for (int i = 0; i < 16; i++) c[4 * i +: 4] = rand_digit();
        return c;
    endfunction

    // Pattern bytes half the time so partial matches and restarts happen often
    function automatic logic [7:0] rand_card_byte();
        if ($urandom_range(0, 1) == 0) return plan_pat[8 * $urandom_range(0, 2) +: 8];
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic void enter_code(input bit right);
        int         n;
        int         bad;
        logic [3:0] k;
        logic [3:0] alt;
        n   = (plan_len > 16) ? 16 : int'(plan_len);
        bad = -1;
        if (!right) begin
            if (n == 0) add_key(rand_digit());
            else bad = $urandom_range(0, n - 1);
        end
        for (int i = 0; i < n; i++) begin
            k = plan_code[4 * i +: 4];
            if (i == bad) begin
                alt = rand_digit();
                while (alt == k) alt = rand_digit();
                k = alt;
            end
            add_key(k);
        end
        add_key(KEY_HASH);
    endfunction

    function automatic void card_block(input bit embed);
        logic [7:0] bytes_q[$];
        int         n;
        n = $urandom_range(0, 4);
        repeat (n) bytes_q.push_back(rand_card_byte());
        if (embed) begin
            bytes_q.push_back(plan_pat[23:16]);
            bytes_q.push_back(plan_pat[15:8]);
            bytes_q.push_back(plan_pat[7:0]);
        end
        n = $urandom_range(0, 2);
        repeat (n) bytes_q.push_back(rand_card_byte());
        if (bytes_q.size() == 0) bytes_q.push_back(rand_card_byte());
        foreach (bytes_q[i]) add_card(bytes_q[i], i == bytes_q.size() - 1);
    endfunction

    // Code, card, then the key that ends the open state
    function automatic void lock_cycle();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) begin
            add_key(KEY_STAR);
        end else if (r == 1) begin
            add_key(rand_digit());
            add_key(KEY_STAR);
        end
        enter_code($urandom_range(0, 4) != 0);
        if ($urandom_range(0, 6) == 0) add_key(KEY_HASH);
        if ($urandom_range(0, 9) == 0) begin
            if ($urandom_range(0, 1) == 0) add_card(rand_card_byte(), 1'b0);
            add_beat(REQ_CARD_ERR, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
                     1'($urandom_range(0, 1)));
        end else begin
            card_block($urandom_range(0, 9) < 7);
        end
        if ($urandom_range(0, 4) < 3) add_key(KEY_HASH);
        else add_key(4'($urandom_range(0, 15)));
    endfunction

    function automatic void overflow_run();
        repeat ($urandom_range(15, 19)) add_key(rand_digit());
        add_key(KEY_HASH);
    endfunction

    function automatic void random_phase();
        int stop_at;
        int r;
        stop_at = stim_items + PHASE_ITEMS;
        while (stim_items < stop_at) begin
            r = $urandom_range(0, 99);
            if (r < 62) begin
                lock_cycle();
            end else if (r < 78) begin
                repeat ($urandom_range(1, 3)) add_noise();
            end else if (r < 86) begin
                overflow_run();
            end else if (r < 95) begin
                add_key(4'($urandom_range(0, 15)));
            end else begin
                add_drain();
                lock_cycle();
            end
        end
    endfunction

    // ---------------------------------------------------------------
    // Request driver
    // ---------------------------------------------------------------

    int send_gap   = 0;
    bit send_burst = 1'b0;

    always @(posedge i_clk) begin
        logic        nxt_valid;
        t_req        nxt_beat;
        logic        nxt_we;
        logic [1:0]  nxt_idx;
        logic [63:0] nxt_wdata;
        bit          idle;
        t_op         head;
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
            i_cfg_we     <= 1'b0;
            lock_model_reset();
            send_gap = 0;
        end else begin
            nxt_valid = req_if.valid;
            nxt_beat  = req_if.data;
            nxt_we    = 1'b0;
            nxt_idx   = i_cfg_idx;
            nxt_wdata = i_cfg_data;
            idle      = !req_if.valid && (beats_sent == beats_seen);

            // accepted beat: predict its result, draw the gap before the next one
            if (req_if.valid && req_if.ready) begin
                rsp_expect_q.push_back(lock_predict(req_if.data));
                beats_sent <= beats_sent + 1;
                nxt_valid = 1'b0;
                if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
                send_gap = send_burst ? 0 : $urandom_range(0, 3);
            end

            if (!nxt_valid && op_q.size() > 0) begin
                case (op_q[0].kind)
                    OP_BEAT: begin
                        if (send_gap > 0) begin
                            send_gap--;
                        end else begin
                            head      = op_q.pop_front();
                            nxt_valid = 1'b1;
                            nxt_beat  = head.beat;
                        end
                    end
                    OP_CFG: begin
                        if (idle) begin
                            head      = op_q.pop_front();
                            nxt_we    = 1'b1;
                            nxt_idx   = head.idx;
                            nxt_wdata = head.value;
                            cfg_apply(head.idx, head.value);
                        end
                    end
                    default: begin
                        if (idle) head = op_q.pop_front();
                    end
                endcase
            end

            req_if.valid <= nxt_valid;
            req_if.data  <= nxt_beat;
            i_cfg_we     <= nxt_we;
            i_cfg_idx    <= nxt_idx;
            i_cfg_data   <= nxt_wdata;
        end
    end

    // ---------------------------------------------------------------
    // Result monitor
    // ---------------------------------------------------------------

    int take_gap   = 0;
    bit take_burst = 1'b0;

    always @(posedge i_clk) begin
        logic nxt_ready;
        t_rsp want;
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
            take_gap = 0;
        end else begin
            nxt_ready = rsp_if.ready;
            if (rsp_if.valid && rsp_if.ready) begin
                beats_seen <= beats_seen + 1;
                if (rsp_expect_q.size() == 0) begin
                    $error("unexpected result beat: status %0d", rsp_if.data.status);
                    fail_cnt++;
                end else begin
                    want = rsp_expect_q.pop_front();
                    if (rsp_if.data.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status,
                               rsp_if.data.status);
                        fail_cnt++;
                    end
                    if (rsp_if.data.lock_open !== want.lock_open) begin
                        $error("lock_open: expected %0d, got %0d", want.lock_open,
                               rsp_if.data.lock_open);
                        fail_cnt++;
                    end
                    if (rsp_if.data.entered_count !== want.entered_count) begin
                        $error("entered_count: expected %0d, got %0d", want.entered_count,
                               rsp_if.data.entered_count);
                        fail_cnt++;
                    end
                end
                if ($urandom_range(0, 39) == 0) take_burst = !take_burst;
                take_gap  = take_burst ? 0 : $urandom_range(0, 3);
                nxt_ready = (take_gap == 0);
            end else if (!rsp_if.ready) begin
                if (take_gap > 0) take_gap--;
                nxt_ready = (take_gap == 0);
            end
            rsp_if.ready <= nxt_ready;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus, reset and end of run
    // ---------------------------------------------------------------

    initial begin
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = CFG_CODE_KEYS;
        i_cfg_data   = '0;
        req_if.valid = 1'b0;
        req_if.data  = '0;
        rsp_if.ready = 1'b0;

        // Directed: reset code 0-1-2-4, pattern 52 75 69
        add_key(4'd0);
        add_key(4'd1);
        add_key(4'd2);
        add_key(4'd4);
        add_key(KEY_HASH);
        add_key(KEY_HASH);                           // hash again while awaiting card
        add_card(8'h52, 1'b0);
        add_card(8'h75, 1'b0);
        add_card(8'h69, 1'b1);                       // hit on the final byte opens
        add_key(4'd15);                              // close cancelled, stays open
        add_key(KEY_STAR);
        add_key(4'd3);
        add_key(KEY_HASH);                           // wrong code
        add_beat(REQ_UNUSED, 4'd15, 8'hFF, 1'b1);
        add_beat(REQ_CARD_ERR, 4'd0, 8'h00, 1'b0);   // card input outside card wait
        add_card(8'h00, 1'b1);
        add_key(4'd0);
        add_key(4'd1);
        add_key(4'd2);
        add_key(4'd4);
        add_key(KEY_HASH);
        add_card(8'hFF, 1'b1);                       // pattern never seen: refused

        // Random phases over several register settings
        plan_code = 64'h4210;
        plan_len  = 5'd4;
        plan_pat  = 24'h527569;
        set_phase(rand_code(), 5'd6, 24'($urandom_range(0, 24'hFFFFFF)));
        random_phase();
        set_phase(64'd0, 5'd0, 24'h000000);
        random_phase();
        set_phase('1, 5'd16, 24'hFFFFFF);
        random_phase();
        set_phase(rand_code(), 5'd31, 24'($urandom_range(0, 24'hFFFFFF)));
        random_phase();
        set_phase(rand_code(), 5'd1, 24'hAAAAAA);
        random_phase();
        set_phase(rand_code(), 5'd3, 24'h5A5A11);
        random_phase();
        set_phase(rand_code(), 5'd16, 24'h11AA11);
        random_phase();

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do @(negedge i_clk);
        while (op_q.size() > 0 || req_if.valid || beats_sent != beats_seen);
        repeat (DRAIN_TICKS) @(negedge i_clk);

        if (rsp_expect_q.size() > 0) begin
            $error("%0d expected results never arrived", rsp_expect_q.size());
            fail_cnt++;
        end
        if (fail_cnt == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: keypad_card_lock_controller_top.f
sv/kclc_pkg.sv
sv/kclc_stream_if.sv
sv/kclc_in_reg.sv
sv/kclc_ctrl.sv
sv/kclc_out_reg.sv
sv/keypad_card_lock_controller_top.sv
tb/sv/testbench.sv
